// ===== rtl/ppd_pkg.sv =====
// shared types, constants and command/status structs of the p-norm distance unit
package ppd_pkg;

    // field and datapath widths
    localparam int ELEM_W      = 16;
    localparam int DIFF_W      = 16;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = 48;
    localparam int DIST_W      = 32;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int MODE_W      = 2;
    localparam int MAX_LEN_DEF = 4096;

    // norm mode codes
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EUCL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MAX   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_EUCL;

    // controller states
    typedef enum logic [2:0] {
        S_RUN,
        S_DRAIN,
        S_PICK,
        S_ROOT,
        S_LOAD
    } t_ppd_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic root_start;
        logic load;
        logic clear;
    } t_ppd_cmd;

    // datapath to controller
    typedef struct packed {
        logic take_final;
        logic fold_final;
        logic fin_root;
        logic root_done;
        logic out_free;
    } t_ppd_status;

endpackage

// ===== rtl/ppd_isqrt.sv =====
// iterative integer square root, one result bit per cycle
module ppd_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ppd_pkg::SUM_W-1:0]  i_value,
    output logic                       o_done,
    output logic [ppd_pkg::ROOT_W-1:0] o_root
);
    import ppd_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SUM_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_root, n_root;
    logic [SUM_W-1:0] r_bit, n_bit;
    logic [SUM_W:0]   trial;

    // one restoring step per cycle, starting at the top even bit
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        trial  = {1'b0, r_root} + {1'b0, r_bit};
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = i_value;
            n_root = '0;
            n_bit  = {{(SUM_W-1){1'b0}}, 1'b1} << (SUM_W - 2);
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                n_rem  = r_rem - trial[SUM_W-1:0];
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

// ===== rtl/ppd_datapath.sv =====
// difference, square and accumulate pipeline, finishing logic and output register
module ppd_datapath #(
    parameter int MAX_LEN = ppd_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ppd_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  logic                         i_s_tvalid,
    input  logic [2*ppd_pkg::ELEM_W-1:0] i_s_tdata,
    input  logic                         i_s_tlast,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [ppd_pkg::DIST_W-1:0]   o_m_tdata,
    output logic                         o_m_tuser,
    input  ppd_pkg::t_ppd_cmd            i_cmd,
    output ppd_pkg::t_ppd_status         o_status
);
    import ppd_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_count;
    logic              accept;
    logic              is_final;

    logic signed [ELEM_W:0] diff_s;
    logic signed [ELEM_W:0] diff_n;
    logic [DIFF_W-1:0]      abs_diff;

    logic              r_s1_valid;
    logic              r_s1_last;
    logic [MODE_W-1:0] r_s1_mode;
    logic [DIFF_W-1:0] r_s1_diff;

    logic              r_s2_valid;
    logic              r_s2_last;
    logic [MODE_W-1:0] r_s2_mode;
    logic [DIFF_W-1:0] r_s2_diff;
    logic [SQ_W-1:0]   r_s2_sq;

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  add_val;
    logic [SUM_W:0]    sum_wide;
    logic [MODE_W-1:0] r_fin_mode;

    logic              root_done;
    logic [ROOT_W-1:0] root;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_sat;

    // input transaction and vector end, overlong vectors end at MAX_LEN pairs
    assign accept   = i_s_tvalid & i_cmd.in_ready;
    assign is_final = i_s_tlast | (r_count == CNT_W'(MAX_LEN - 1));

    // norm mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // pair counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= is_final ? '0 : r_count + 1'b1;
        end
    end

    // absolute difference at one bit above the element width
    always_comb begin
        diff_s   = {i_s_tdata[ELEM_W-1], i_s_tdata[ELEM_W-1:0]}
                 - {i_s_tdata[2*ELEM_W-1], i_s_tdata[2*ELEM_W-1:ELEM_W]};
        diff_n   = -diff_s;
        abs_diff = diff_s[ELEM_W] ? diff_n[DIFF_W-1:0] : diff_s[DIFF_W-1:0];
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage one: difference, stage two: square
    always_ff @(posedge i_clk) begin
        r_s1_last <= is_final;
        r_s1_mode <= r_mode;
        r_s1_diff <= abs_diff;
        r_s2_last <= r_s1_last;
        r_s2_mode <= r_s1_mode;
        r_s2_diff <= r_s1_diff;
        r_s2_sq   <= r_s1_diff * r_s1_diff;
    end

    // fold into the accumulator: add with saturation at the top of its range, or keep the maximum in max mode
    always_comb begin
        case (r_s2_mode)
            MODE_COUNT: add_val = {{(SUM_W-1){1'b0}}, (r_s2_diff != '0)};
            MODE_SUM:   add_val = {{(SUM_W-DIFF_W){1'b0}}, r_s2_diff};
            default:    add_val = {{(SUM_W-SQ_W){1'b0}}, r_s2_sq};
        endcase
        sum_wide = {1'b0, r_sum} + {1'b0, add_val};
        n_sum    = r_sum;
        if (i_cmd.clear) begin
            n_sum = '0;
        end else if (r_s2_valid) begin
            if (r_s2_mode == MODE_MAX) begin
                if ({{(SUM_W-DIFF_W){1'b0}}, r_s2_diff} > r_sum) begin
                    n_sum = {{(SUM_W-DIFF_W){1'b0}}, r_s2_diff};
                end
            end else begin
                n_sum = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // mode of the final pair decides the finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_mode <= MODE_RESET;
        end else if (r_s2_valid && r_s2_last) begin
            r_fin_mode <= r_s2_mode;
        end
    end

    // square root unit for the euclidean finish
    ppd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (r_sum),
        .o_done  (root_done),
        .o_root  (root)
    );

    // output register, refilled only once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (r_fin_mode == MODE_EUCL) begin
                r_out_dist <= {{(DIST_W-ROOT_W){1'b0}}, root};
                r_out_sat  <= 1'b0;
            end else if (r_sum[SUM_W-1:DIST_W] != '0) begin
                r_out_dist <= {DIST_W{1'b1}};
                r_out_sat  <= 1'b1;
            end else begin
                r_out_dist <= r_sum[DIST_W-1:0];
                r_out_sat  <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_dist;
    assign o_m_tuser  = r_out_sat;

    // status towards the controller
    always_comb begin
        o_status.take_final = accept & is_final;
        o_status.fold_final = r_s2_valid & r_s2_last;
        o_status.fin_root   = (r_fin_mode == MODE_EUCL);
        o_status.root_done  = root_done;
        o_status.out_free   = ~r_out_valid | i_m_tready;
    end

endmodule

// ===== rtl/ppd_ctrl.sv =====
// controller state machine: streaming, drain, square root and result load
module ppd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppd_pkg::t_ppd_status i_status,
    output ppd_pkg::t_ppd_cmd    o_cmd
);
    import ppd_pkg::*;

    t_ppd_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (i_status.take_final) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_status.fold_final) n_state = S_PICK;
            end
            S_PICK: begin
                n_state = i_status.fin_root ? S_ROOT : S_LOAD;
            end
            S_ROOT: begin
                if (i_status.root_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_RUN: begin
                o_cmd.in_ready = 1'b1;
            end
            S_PICK: begin
                o_cmd.root_start = i_status.fin_root;
            end
            S_LOAD: begin
                o_cmd.load  = i_status.out_free;
                o_cmd.clear = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/pairwise_pnorm_distance_unit.sv =====
// top level of the streamed pairwise p-norm distance unit
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata {elem_b, elem_a}, tlast last_pair
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata distance, tuser saturated
//  cfg       in         i_cfg_we                         i_cfg_wdata norm_mode
//
// element pairs are taken one per cycle while a vector streams.
// after the final pair the input is held off through the pipeline drain, a decision state,
// the bit-serial square root in euclidean mode (24 steps, then a done strobe), and a load
// state.
// the output register holds a finished distance while the next vector streams in; a new
// result waits in the load state until that register is free.
// reset is synchronous and clears the accumulator, pair count and pipeline; norm mode is 2.
module pairwise_pnorm_distance_unit #(
    parameter int MAX_LEN = ppd_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ppd_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // elem_a [15:0], elem_b [31:16]
    input  logic [2*ppd_pkg::ELEM_W-1:0] s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // distance [31:0]
    output logic [ppd_pkg::DIST_W-1:0]   m_axis_tdata,
    // saturated [0]
    output logic                         m_axis_tuser
);
    import ppd_pkg::*;

    t_ppd_cmd    cmd;
    t_ppd_status status;

    // controller
    ppd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    ppd_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule
